### rtl/sha256_pkg.sv
`default_nettype none

package sha256_pkg;

    localparam int unsigned LEN_W = 61;  // message length in bytes, 2^64 bits wrap

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    // working variables a..h of one compression
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } t_work;

    // schedule taps w[t], w[t+1], w[t+9], w[t+14] of the 16-word window
    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w9;
        logic [31:0] w14;
    } t_sched;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd7;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

### rtl/sha256_round.sv
`default_nettype none

// One SHA-256 round plus the next message schedule word.
module sha256_round (
    input  var sha256_pkg::t_work  i_work,
    input  var sha256_pkg::t_sched i_sched,
    input  var logic [31:0]        i_k,
    output var sha256_pkg::t_work  o_work,
    output var logic [31:0]        o_w_next
);
    import sha256_pkg::*;

    logic [31:0] s_t1;
    logic [31:0] s_t2;
    logic [31:0] s_ch;
    logic [31:0] s_maj;

    always_comb begin
        s_ch  = (i_work.e & i_work.f) ^ (~i_work.e & i_work.g);
        s_maj = (i_work.a & i_work.b) ^ (i_work.a & i_work.c) ^ (i_work.b & i_work.c);
        s_t1  = i_work.h + big_s1(i_work.e) + s_ch + i_k + i_sched.w0;
        s_t2  = big_s0(i_work.a) + s_maj;

        o_work.h = i_work.g;
        o_work.g = i_work.f;
        o_work.f = i_work.e;
        o_work.e = i_work.d + s_t1;
        o_work.d = i_work.c;
        o_work.c = i_work.b;
        o_work.b = i_work.a;
        o_work.a = s_t1 + s_t2;

        o_w_next = small_s1(i_sched.w14) + i_sched.w9 + small_s0(i_sched.w1) + i_sched.w0;
    end

endmodule

`default_nettype wire

### rtl/sha256_stream_hasher.sv
`default_nettype none

// SHA-256 over a byte stream. One byte is taken per accepted input. The byte
// that fills the 64-byte block starts a compression on a single shared
// round unit, one round per cycle: 64 rounds and then an add into the hash.
// On end of message the padding bytes go in one per cycle (up to 64 of
// them, 72 when the length spills into a second block), each padded block
// is compressed as above, and the eight digest words are then offered one
// per cycle while the output is ready, word 0 first.
// Input ready is low while a block is compressed, and from end of message
// until the last digest word has been taken.
module sha256_stream_hasher (
    input  var logic            i_clk,
    input  var logic            i_rst_n,
    input  var logic            i_in_valid,
    output var logic            o_in_ready,
    input  var sha256_pkg::t_in i_in,
    output var logic            o_out_valid,
    input  var logic            i_out_ready,
    output var sha256_pkg::t_out o_out
);
    import sha256_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [5:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [2:0]  r_idx;
    logic [LEN_W-1:0] r_len;
    logic        r_pad;
    logic        r_first;
    logic        r_last;
    logic [31:0] r_h [8];
    logic [31:0] r_w [16];
    t_work       r_work;

    logic        s_take;
    logic        s_shift;
    logic        s_blk_full;
    logic        s_out_take;
    logic        s_msg_done;
    logic [7:0]  s_byte;
    logic [7:0]  s_pad_byte;
    logic [63:0] s_bits;
    logic [63:0] s_len_sh;
    t_work       s_work_next;
    t_sched      s_sched;
    logic [31:0] s_w_next;

    // length bytes, big-endian, at positions 56..63 of the final block
    assign s_bits   = {r_len, 3'b000};
    assign s_len_sh = s_bits >> {~r_fill[2:0], 3'b000};

    always_comb begin
        if (r_first) begin
            s_pad_byte = PAD_BYTE;
        end else if (r_last && (r_fill >= LEN_POS)) begin
            s_pad_byte = s_len_sh[7:0];
        end else begin
            s_pad_byte = 8'd0;
        end
    end

    assign s_sched = '{w0: r_w[0], w1: r_w[1], w9: r_w[9], w14: r_w[14]};

    sha256_round u_round (
        .i_work   (r_work),
        .i_sched  (s_sched),
        .i_k      (K_ROUND[r_rnd]),
        .o_work   (s_work_next),
        .o_w_next (s_w_next)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_take) begin
                    if (i_in.has_byte && (r_fill == LAST_POS)) begin
                        n_state = ST_ROUND;
                    end else if (i_in.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_fill == LAST_POS) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_rnd == LAST_POS) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!r_pad) begin
                    n_state = ST_IDLE;
                end else if (r_last) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (s_msg_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath strobes
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        s_take      = i_in_valid && o_in_ready;
        s_shift     = (s_take && i_in.has_byte) || (r_state == ST_PAD);
        s_byte      = (r_state == ST_PAD) ? s_pad_byte : i_in.data_byte;
        s_blk_full  = s_shift && (r_fill == LAST_POS);
        s_out_take  = o_out_valid && i_out_ready;
        s_msg_done  = s_out_take && (r_idx == LAST_IDX);
        o_out.digest_word = r_h[r_idx];
        o_out.word_index  = r_idx;
        o_out.last_word   = (r_idx == LAST_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= 6'd0;
            r_rnd   <= 6'd0;
            r_idx   <= 3'd0;
            r_len   <= '0;
            r_pad   <= 1'b0;
            r_first <= 1'b0;
            r_last  <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else begin
            r_state <= n_state;
            if (s_shift) begin
                r_fill <= r_fill + 6'd1;
            end
            if (r_state == ST_ROUND) begin
                r_rnd <= r_rnd + 6'd1;
            end
            if (s_out_take) begin
                r_idx <= r_idx + 3'd1;
            end
            if (s_take && i_in.has_byte) begin
                r_len <= r_len + {{(LEN_W-1){1'b0}}, 1'b1};
            end
            if (s_take && i_in.end_of_message) begin
                r_pad   <= 1'b1;
                r_first <= 1'b1;
                r_last  <= 1'b0;
            end
            if ((r_state == ST_PAD) && r_first) begin
                r_first <= 1'b0;
                r_last  <= (r_fill < LEN_POS);
            end
            // length not yet in a block: the next padded block is the final one
            if ((r_state == ST_ADD) && r_pad && !r_last) begin
                r_last <= 1'b1;
            end
            if (r_state == ST_ADD) begin
                r_h[0] <= r_h[0] + r_work.a;
                r_h[1] <= r_h[1] + r_work.b;
                r_h[2] <= r_h[2] + r_work.c;
                r_h[3] <= r_h[3] + r_work.d;
                r_h[4] <= r_h[4] + r_work.e;
                r_h[5] <= r_h[5] + r_work.f;
                r_h[6] <= r_h[6] + r_work.g;
                r_h[7] <= r_h[7] + r_work.h;
            end
            if (s_msg_done) begin
                r_len  <= '0;
                r_pad  <= 1'b0;
                r_last <= 1'b0;
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= H_INIT[i];
                end
            end
        end
    end

    // block window and working variables
    always_ff @(posedge i_clk) begin
        if (s_shift) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= {r_w[j][23:0], r_w[j+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], s_byte};
        end else if (r_state == ST_ROUND) begin
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= s_w_next;
        end
        if (s_blk_full) begin
            r_work <= '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3],
                        e: r_h[4], f: r_h[5], g: r_h[6], h: r_h[7]};
        end else if (r_state == ST_ROUND) begin
            r_work <= s_work_next;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while digest pending");

    a_round_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == LAST_POS) |=> (r_state == ST_ADD))
        else $error("compression did not finish after last round");

    a_fill_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_fill == 6'd0))
        else $error("digest offered with bytes still in the block");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.last_word) |=>
        (o_out_valid && (o_out.word_index == $past(o_out.word_index) + 3'd1)))
        else $error("digest word order broken");

endmodule

`default_nettype wire
